[rtl/piqbs_pkg.sv]
// Shared types and codes for the positional insert job queue.
`timescale 1ns / 1ps

package piqbs_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 16;

  // Request codes
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_SCAN   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SERVED = 2'd1;
  localparam logic [1:0] KIND_TOTAL  = 2'd2;

  // Cost total saturates here
  localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

  // Input item
  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] item_id;
    logic [15:0] time_value;
    logic [15:0] cost;
    logic [7:0]  position;
  } piqbs_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] served_id;
    logic [19:0] total_cost;
    logic [4:0]  item_count;
    logic        queue_empty;
    logic        dropped;
    logic        last;
  } piqbs_out_t;

  // One stored job
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] dur;
    logic [15:0] cost;
  } job_t;

  localparam int JOB_W = $bits(job_t);

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic pop;
    logic rd_prev;
    logic rd_cur;
    logic wr_shift;
    logic wr_new;
    logic serve;
    logic emit_status;
    logic emit_served;
    logic emit_total;
  } piqbs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       shift_more;
    logic       scan_more;
    logic       fits;
    logic       out_free;
  } piqbs_stat_t;

endpackage

[rtl/piqbs_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module piqbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/piqbs_datapath.sv]
// Queue storage, pointers, scan accumulators and result register.
`timescale 1ns / 1ps

module piqbs_datapath
  import piqbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  piqbs_in_t   in_data,
  input  piqbs_cmd_t  cmd,
  output piqbs_stat_t stat,
  output logic        out_valid,
  input  logic        out_stall,
  output piqbs_out_t  out_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LW     = (CNT_W > 8) ? CNT_W : 8;

  // Queue state
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;

  // Request state
  logic [1:0]        func;
  job_t              new_job;
  logic [CNT_W-1:0]  slot;
  logic [CNT_W-1:0]  idx;
  logic              drop;
  logic [15:0]       budget;
  logic [19:0]       total;

  // RAM ports
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [JOB_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [JOB_W-1:0]  ram_rd_data;
  job_t              rd_job;

  logic [CNT_W-1:0]  rd_logical;
  logic [CNT_W-1:0]  wr_logical;
  logic [7:0]        pos_m1;
  logic [CNT_W-1:0]  slot_next;
  logic [20:0]       total_sum;
  logic [19:0]       total_next;
  logic              full;
  logic              empty;
  logic              out_free;

  // Logical index to circular address
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [CNT_W-1:0] lidx);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + (ADDR_W + 1)'(lidx);
    if (sum >= (ADDR_W + 1)'(DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign out_free = !out_valid || !out_stall;
  assign rd_job   = job_t'(ram_rd_data);

  // Insert slot: position 0 acts as 1, beyond count appends
  always_comb begin
    pos_m1 = (in_data.position == 8'd0) ? 8'd0 : in_data.position - 8'd1;
    if (in_data.func == FUNC_APPEND) begin
      slot_next = count;
    end else if (LW'(pos_m1) > LW'(count)) begin
      slot_next = count;
    end else begin
      slot_next = CNT_W'(pos_m1);
    end
  end

  // Saturating cost accumulate
  always_comb begin
    total_sum  = {1'b0, total} + 21'(rd_job.cost);
    total_next = (total_sum > 21'(TOTAL_MAX)) ? TOTAL_MAX : total_sum[19:0];
  end

  // RAM addressing
  assign rd_logical  = cmd.rd_prev ? idx - CNT_W'(1) : idx;
  assign wr_logical  = cmd.wr_shift ? idx : slot;
  assign ram_rd_en   = cmd.rd_prev || cmd.rd_cur;
  assign ram_rd_addr = phys(head, rd_logical);
  assign ram_wr_en   = cmd.wr_shift || cmd.wr_new;
  assign ram_wr_addr = phys(head, wr_logical);
  assign ram_wr_data = cmd.wr_shift ? ram_rd_data : JOB_W'(new_job);

  piqbs_ram #(
    .WIDTH (JOB_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Status to controller
  always_comb begin
    stat.func       = func;
    stat.full       = full;
    stat.shift_more = (idx > slot);
    stat.scan_more  = (idx < count);
    stat.fits       = (budget > rd_job.dur);
    stat.out_free   = out_free;
  end

  // Queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.wr_new) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop && !empty) begin
      head  <= (head == ADDR_W'(DEPTH - 1)) ? '0 : head + ADDR_W'(1);
      count <= count - CNT_W'(1);
    end
  end

  // Request registers and walk index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func         <= in_data.func;
      new_job.id   <= in_data.item_id;
      new_job.dur  <= in_data.time_value;
      new_job.cost <= in_data.cost;
      slot         <= slot_next;
      idx          <= (in_data.func == FUNC_SCAN) ? '0 : count;
      drop         <= full && (in_data.func == FUNC_APPEND || in_data.func == FUNC_INSERT);
      budget       <= in_data.time_value;
      total        <= '0;
    end else if (cmd.wr_shift) begin
      idx <= idx - CNT_W'(1);
    end else if (cmd.serve) begin
      idx    <= idx + CNT_W'(1);
      budget <= budget - rd_job.dur;
      total  <= total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_status || cmd.emit_served || cmd.emit_total) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status || cmd.emit_served || cmd.emit_total) begin
      out_data.item_count  <= 5'(count);
      out_data.queue_empty <= empty;
      out_data.served_id   <= cmd.emit_served ? rd_job.id : 16'd0;
      out_data.total_cost  <= cmd.emit_total ? total : 20'd0;
      out_data.dropped     <= cmd.emit_status && drop;
      out_data.last        <= !cmd.emit_served;
      if (cmd.emit_served) begin
        out_data.kind <= KIND_SERVED;
      end else if (cmd.emit_total) begin
        out_data.kind <= KIND_TOTAL;
      end else begin
        out_data.kind <= KIND_STATUS;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("job count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_status || cmd.emit_served || cmd.emit_total) |-> out_free)
    else $error("result emitted over an untaken result");

  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |=> count == $past(count) + CNT_W'(1))
    else $error("placed job did not grow the count");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> !full)
    else $error("job placed into a full queue");

endmodule

[rtl/piqbs_ctrl.sv]
// Request sequencer for the job queue.
`timescale 1ns / 1ps

module piqbs_ctrl
  import piqbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  piqbs_stat_t stat,
  output piqbs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_TOTAL,
    S_STATUS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.func)
          FUNC_APPEND, FUNC_INSERT: begin
            state_next = stat.full ? S_STATUS : S_SHIFT_RD;
          end
          FUNC_REMOVE: begin
            cmd.pop    = 1'b1;
            state_next = S_STATUS;
          end
          FUNC_SCAN: begin
            state_next = S_SCAN_RD;
          end
          default: begin
            state_next = S_STATUS;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SHIFT_WR;
        end else begin
          cmd.wr_new = 1'b1;
          state_next = S_STATUS;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_SCAN_RD: begin
        if (stat.scan_more) begin
          cmd.rd_cur = 1'b1;
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_TOTAL;
        end
      end
      S_SCAN_CHK: begin
        if (!stat.fits) begin
          state_next = S_TOTAL;
        end else if (stat.out_free) begin
          cmd.serve       = 1'b1;
          cmd.emit_served = 1'b1;
          state_next      = S_SCAN_RD;
        end
      end
      S_TOTAL: begin
        if (stat.out_free) begin
          cmd.emit_total = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/positional_insert_queue_budget_scan.sv]
// Top level of the bounded job queue with positional insert and budget scan.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | in_data  (piqbs_in_t)
//   output  | out_valid | out_stall | out_data (piqbs_out_t)
//
// One request at a time; in_stall is high from acceptance until its last result is queued.
// Append places the job with no moves. Insert at slot s first moves each job from slot s
// onward up by one, a read state then a write state per moved job, set by the single RAM
// write port and its registered read. Budget scan: one RAM read and one check per job,
// until a job does not fit or all jobs have been served.
// Output stalls hold the sequencer in place. Synchronous reset empties the queue.
`timescale 1ns / 1ps

module positional_insert_queue_budget_scan
  import piqbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  piqbs_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output piqbs_out_t out_data
);

  piqbs_cmd_t  cmd;
  piqbs_stat_t stat;

  piqbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  piqbs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
